[rtl/rmf_pkg.sv]
// Package for the recursive median filter: sizes, sample type, command and
// result records shared by the front end, the queues and the back end.
// Depends on nothing.
`timescale 1ns / 1ps

package rmf_pkg;

   localparam int MAX_KERNEL   = 21;
   localparam int SAMPLE_WIDTH = 16;
   localparam int HALF_W       = 4;
   localparam int HALF_MAX     = (MAX_KERNEL - 1) / 2;
   localparam int HALF_RESET   = 5;

   localparam int STORE_DEPTH = MAX_KERNEL - 1;
   localparam int SORT_DEPTH  = MAX_KERNEL;
   localparam int FILL_W      = $clog2(STORE_DEPTH + 1);
   localparam int STORE_IDX_W = $clog2(STORE_DEPTH);
   localparam int SORT_IDX_W  = $clog2(SORT_DEPTH);
   localparam int SORT_CNT_W  = $clog2(SORT_DEPTH + 1);

   // Queue depth must be a power of two so the pointers wrap on their own.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;

   typedef enum logic [1:0] {
      OP_NONE   = 2'd0,
      OP_PASS   = 2'd1,
      OP_MEDIAN = 2'd2
   } op_type;

   typedef struct packed {
      sample_type          sample;
      op_type              op;
      logic [HALF_W-1:0]   half;
      logic [HALF_W-1:0]   flush;
      logic                block_end;
   } cmd_type;

   typedef struct packed {
      sample_type sample;
      logic       last;
   } rsp_type;

endpackage

[rtl/rmf_cmd_queue.sv]
// Two-entry command queue between the front end and the back end.
// Depends on rmf_pkg.
`timescale 1ns / 1ps

module rmf_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rmf_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output rmf_pkg::cmd_type head,
   output logic             empty
);
   import rmf_pkg::*;

   cmd_type                mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   push_ok, pop_ok;

   assign full    = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = mem_ff[rd_ptr_ff];
   assign push_ok = push && !full;
   assign pop_ok  = pop && !empty;

   always_comb begin
      wr_ptr_in = push_ok ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/rmf_rsp_queue.sv]
// Two-entry result queue that drives the result ports.
// Depends on rmf_pkg.
`timescale 1ns / 1ps

module rmf_rsp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rmf_pkg::rsp_type push_data,
   output logic             full,
   input  logic             pop,
   output rmf_pkg::rsp_type head,
   output logic             empty
);
   import rmf_pkg::*;

   rsp_type                mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   push_ok, pop_ok;

   assign full    = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = mem_ff[rd_ptr_ff];
   assign push_ok = push && !full;
   assign pop_ok  = pop && !empty;

   always_comb begin
      wr_ptr_in = push_ok ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/rmf_front.sv]
// Front end: holds the half-width register and the block fill count, and
// turns each request into a command for the back end.
// Depends on rmf_pkg.
`timescale 1ns / 1ps

module rmf_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   input  rmf_pkg::sample_type          req_sample_in,
   input  logic                         req_block_end,
   output logic                         req_full,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [rmf_pkg::HALF_W-1:0]   csr_half_width,
   output logic                         cmd_push,
   output rmf_pkg::cmd_type             cmd_data,
   input  logic                         cmd_full
);
   import rmf_pkg::*;

   logic [HALF_W-1:0] half_width_ff, half_width_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [HALF_W-1:0] half;
   logic [FILL_W-1:0] fill_next;
   logic              accept;

   assign csr_ready = 1'b1;
   assign req_full  = cmd_full;
   assign accept    = req_push && !cmd_full;
   assign cmd_push  = accept;

   // Out-of-range settings are clamped into the supported kernel sizes.
   always_comb begin
      if (half_width_ff == '0) begin
         half = HALF_W'(1);
      end else if (half_width_ff > HALF_W'(HALF_MAX)) begin
         half = HALF_W'(HALF_MAX);
      end else begin
         half = half_width_ff;
      end
   end

   always_comb begin
      half_width_in = (csr_valid && csr_ready) ? csr_half_width : half_width_ff;

      fill_next = (fill_ff < FILL_W'(STORE_DEPTH)) ? fill_ff + 1'b1 : fill_ff;

      cmd_data.sample    = req_sample_in;
      cmd_data.half      = half;
      cmd_data.block_end = req_block_end;
      if (fill_ff < FILL_W'(half)) begin
         cmd_data.op = OP_NONE;
      end else if (fill_ff < FILL_W'({half, 1'b0})) begin
         cmd_data.op = OP_PASS;
      end else begin
         cmd_data.op = OP_MEDIAN;
      end
      // Positions still owed when the block ends, counted after this sample.
      cmd_data.flush = (fill_next < FILL_W'(half)) ? HALF_W'(fill_next) : half;

      fill_in = fill_ff;
      if (accept) begin
         fill_in = req_block_end ? '0 : fill_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_width_ff <= HALF_W'(HALF_RESET);
         fill_ff       <= '0;
      end else begin
         half_width_ff <= half_width_in;
         fill_ff       <= fill_in;
      end
   end

endmodule

[rtl/rmf_back.sv]
// Back end: sample line, insertion sorter and the sequencer that emits the
// median, pass-through and end-of-block flush results.
// Depends on rmf_pkg.
`timescale 1ns / 1ps

module rmf_back (
   input  logic             clock,
   input  logic             reset,
   input  rmf_pkg::cmd_type cmd_head,
   input  logic             cmd_empty,
   output logic             cmd_pop,
   output logic             rsp_push,
   output rmf_pkg::rsp_type rsp_data,
   input  logic             rsp_full
);
   import rmf_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SORT   = 4'b0010,
      ST_UPDATE = 4'b0100,
      ST_FLUSH  = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   cmd_type                cmd_ff, cmd_in;
   sample_type             store_ff [STORE_DEPTH];
   sample_type             store_in [STORE_DEPTH];
   sample_type             sorted_ff [SORT_DEPTH];
   sample_type             sorted_in [SORT_DEPTH];
   logic [SORT_CNT_W-1:0]  sort_cnt_ff, sort_cnt_in;
   logic [HALF_W-1:0]      flush_ff, flush_in;

   logic [STORE_IDX_W-1:0] rd_idx;
   sample_type             rd_data;
   sample_type             ins_data;
   sample_type             med;
   sample_type             result;
   logic [SORT_CNT_W-1:0]  sort_len;
   logic [SORT_DEPTH-1:0]  gt;

   // One read port on the sample line, steered by the sequencer state.
   always_comb begin
      unique case (state_ff)
         ST_SORT: begin
            rd_idx = (sort_cnt_ff == '0) ? '0 : STORE_IDX_W'(sort_cnt_ff - 1'b1);
         end
         ST_UPDATE: begin
            rd_idx = STORE_IDX_W'(cmd_ff.half - HALF_W'(1));
         end
         ST_FLUSH: begin
            rd_idx = STORE_IDX_W'(flush_ff - HALF_W'(1));
         end
         default: begin
            rd_idx = '0;
         end
      endcase
   end

   assign rd_data  = store_ff[rd_idx];
   assign med      = sorted_ff[SORT_IDX_W'(cmd_ff.half)];
   assign result   = (cmd_ff.op == OP_MEDIAN) ? med : rd_data;
   assign sort_len = SORT_CNT_W'({cmd_ff.half, 1'b0}) + 1'b1;
   assign ins_data = (sort_cnt_ff == '0) ? cmd_ff.sample : rd_data;

   // The sorted list is ascending; slots not yet filled act as plus infinity,
   // so the new value lands in front of the first larger entry.
   always_comb begin
      for (int i = 0; i < SORT_DEPTH; i++) begin
         gt[i] = (SORT_CNT_W'(i) >= sort_cnt_ff) || (sorted_ff[i] > ins_data);
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      store_in    = store_ff;
      sorted_in   = sorted_ff;
      sort_cnt_in = sort_cnt_ff;
      flush_in    = flush_ff;
      cmd_pop     = 1'b0;
      rsp_push    = 1'b0;
      rsp_data.sample = result;
      rsp_data.last   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop     = 1'b1;
               cmd_in      = cmd_head;
               sort_cnt_in = '0;
               state_in    = (cmd_head.op == OP_MEDIAN) ? ST_SORT : ST_UPDATE;
            end
         end
         ST_SORT: begin
            if (sort_cnt_ff == sort_len) begin
               state_in = ST_UPDATE;
            end else begin
               sorted_in[0] = gt[0] ? ins_data : sorted_ff[0];
               for (int i = 1; i < SORT_DEPTH; i++) begin
                  sorted_in[i] = gt[i-1] ? sorted_ff[i-1] :
                                 (gt[i] ? ins_data : sorted_ff[i]);
               end
               sort_cnt_in = sort_cnt_ff + 1'b1;
            end
         end
         ST_UPDATE: begin
            if ((cmd_ff.op == OP_NONE) || !rsp_full) begin
               rsp_push = (cmd_ff.op != OP_NONE);
               // The filtered value replaces its position, then the line shifts.
               store_in[0] = cmd_ff.sample;
               for (int a = 1; a < STORE_DEPTH; a++) begin
                  store_in[a] = (STORE_IDX_W'(a) == STORE_IDX_W'(cmd_ff.half)) ?
                                result : store_ff[a-1];
               end
               if (cmd_ff.block_end) begin
                  flush_in = cmd_ff.flush;
                  state_in = ST_FLUSH;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FLUSH: begin
            rsp_data.sample = rd_data;
            rsp_data.last   = (flush_ff == HALF_W'(1));
            if (!rsp_full) begin
               rsp_push = 1'b1;
               flush_in = flush_ff - 1'b1;
               if (flush_ff == HALF_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         sort_cnt_ff <= '0;
         flush_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         sort_cnt_ff <= sort_cnt_in;
         flush_ff    <= flush_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      store_ff  <= store_in;
      sorted_ff <= sorted_in;
   end

endmodule

[rtl/recursive_median_filter.sv]
// Top level of the recursive median filter: front end, command queue,
// back end and result queue. Depends on rmf_pkg and the rmf_* modules.
//
//   channel   direction  handshake              payload
//   req_      in         push / full            sample_in, block_end
//   rsp_      out        pop / empty            sample_out, last_out
//   csr_      in         valid / ready          half_width
//
// A request that produces a median goes from idle through the insertion
// sorter, which takes in the window entries one by one, to the update state;
// other requests skip the sorter, and a block end adds the flush results.
// Reset is synchronous and clears the fill count, the queues and the sequencer.
// The two-entry queues let requests and results stall independently.
`timescale 1ns / 1ps

module recursive_median_filter (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   input  rmf_pkg::sample_type        req_sample_in,
   input  logic                       req_block_end,
   output logic                       req_full,
   input  logic                       rsp_pop,
   output rmf_pkg::sample_type        rsp_sample_out,
   output logic                       rsp_last_out,
   output logic                       rsp_empty,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [rmf_pkg::HALF_W-1:0] csr_half_width
);
   import rmf_pkg::*;

   cmd_type cmd_wr_data;
   cmd_type cmd_head;
   logic    cmd_push, cmd_full, cmd_pop, cmd_empty;
   rsp_type rsp_wr_data;
   rsp_type rsp_head;
   logic    rsp_push, rsp_full;

   rmf_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_sample_in  (req_sample_in),
      .req_block_end  (req_block_end),
      .req_full       (req_full),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_half_width (csr_half_width),
      .cmd_push       (cmd_push),
      .cmd_data       (cmd_wr_data),
      .cmd_full       (cmd_full)
   );

   rmf_cmd_queue u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_wr_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .head      (cmd_head),
      .empty     (cmd_empty)
   );

   rmf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_head  (cmd_head),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_wr_data),
      .rsp_full  (rsp_full)
   );

   rmf_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_wr_data),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .head      (rsp_head),
      .empty     (rsp_empty)
   );

   assign rsp_sample_out = rsp_head.sample;
   assign rsp_last_out   = rsp_head.last;

endmodule

[rtl/rmf_checker.sv]
// Port-level checker for the recursive median filter, bound to the top level.
// Depends on rmf_pkg.
`timescale 1ns / 1ps

module rmf_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_push,
   input logic                req_full,
   input logic                rsp_pop,
   input rmf_pkg::sample_type rsp_sample_out,
   input logic                rsp_last_out,
   input logic                rsp_empty
);

   // Both queues come out of reset empty.
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   a_reset_not_full: assert property (@(posedge clock) reset |=> !req_full)
      else $error("request side full after reset");

   // The request side can only fill up because of a request taken just before.
   a_full_after_push: assert property (@(posedge clock) disable iff (reset)
      $rose(req_full) |-> $past(req_push))
      else $error("request side became full without a request");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_sample_out) && $stable(rsp_last_out)))
      else $error("waiting result changed before it was taken");

endmodule

bind recursive_median_filter rmf_checker u_checker (.*);
